// ----- rtl/core/dpcm_pkg.sv -----
// Shared types and constants for the DPCM prefix-code encoder.
package dpcm_pkg;

  localparam int unsigned PixelW   = 8;
  localparam int unsigned ValidW   = 4;
  localparam int unsigned CodeW    = 12;  // longest code word
  localparam int unsigned AccW     = 7;   // pending bits carried between items
  localparam int unsigned CountW   = 3;
  localparam int unsigned NumSlots = 3;   // most bytes one item can produce
  localparam int unsigned WinW     = 24;  // pending bits plus longest code, byte aligned
  localparam int unsigned OutDataW = 16;

  localparam logic [ValidW-1:0] FullByteBits = 4'd8;

  // prefix codes and class limits
  localparam logic [1:0] Prefix2 = 2'b10;
  localparam logic [2:0] Prefix3 = 3'b110;
  localparam logic [2:0] Prefix4 = 3'b111;
  localparam logic [8:0] Limit1  = 9'd2;
  localparam logic [8:0] Limit2  = 9'd6;
  localparam logic [8:0] Limit3  = 9'd22;

  typedef struct packed {
    logic [PixelW-1:0] data;
    logic [ValidW-1:0] vbits;
    logic              last;
  } byte_slot_t;

endpackage

// ----- rtl/core/dpcm_prefix_code_encoder.sv -----
// DPCM prefix-code encoder: pixel stream in, packed code bytes out.
// An accepted pixel passes through the input register, then the result buffer, to the output.
// The 3-slot byte buffer drains one byte per cycle while the output is ready; a new pixel
//   enters it only when it is empty or its last byte is draining.
// An input register takes a new pixel while buffered bytes still wait.
// Reset (rst, synchronous): buffers empty, next pixel goes out raw.
module dpcm_prefix_code_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dpcm_pkg::PixelW-1:0]       s_axis_tdata,   // [7:0] pixel
  input  logic                              s_axis_tlast,   // last_pixel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dpcm_pkg::OutDataW-1:0]     m_axis_tdata,   // [7:0] out_byte, [11:8] valid_bits
  output logic                              m_axis_tlast    // last_byte
);
  import dpcm_pkg::*;

  // input register
  logic              in_full;
  logic [PixelW-1:0] in_pixel;
  logic              in_last;

  // encoder state
  logic [PixelW-1:0] prev_pixel;
  logic              first_pending;
  logic [AccW-1:0]   acc_la;     // pending bits, left aligned, zeros below
  logic [CountW-1:0] bit_count;

  // result buffer
  byte_slot_t        slots [NumSlots];
  logic [1:0]        cnt;

  logic drain, load, move;

  assign drain = m_axis_tvalid && m_axis_tready;
  assign load  = (cnt == 2'd0) || (cnt == 2'd1 && drain);
  assign move  = in_full && load;
  assign s_axis_tready = !in_full || move;

  // ---- encode ----
  logic              neg;
  logic [8:0]        diff_pos, diff_neg, mag;
  logic [8:0]        m2, m6, m22;
  logic [CodeW-1:0]  code_la;
  logic [3:0]        ncode;
  logic [4:0]        total;
  logic [1:0]        nfull;
  logic [2:0]        rem;
  logic [WinW-1:0]   win;
  logic [PixelW-1:0] bytes [NumSlots];
  logic [PixelW-1:0] tail;
  byte_slot_t        res [NumSlots];
  logic [1:0]        nres;
  logic              flush;

  always_comb begin
    neg      = in_pixel < prev_pixel;
    diff_pos = {1'b0, in_pixel} - {1'b0, prev_pixel};
    diff_neg = {1'b0, prev_pixel} - {1'b0, in_pixel};
    mag      = neg ? diff_neg : diff_pos;
    m2       = mag - Limit1;
    m6       = mag - Limit2;
    m22      = mag - Limit3;
    if (first_pending) begin
      code_la = {in_pixel, 4'b0};
      ncode   = 4'd8;
    end else if (mag < Limit1) begin
      code_la = {1'b0, mag[0], neg, 9'b0};
      ncode   = 4'd3;
    end else if (mag < Limit2) begin
      code_la = {Prefix2, m2[1:0], neg, 7'b0};
      ncode   = 4'd5;
    end else if (mag < Limit3) begin
      code_la = {Prefix3, m6[3:0], neg, 4'b0};
      ncode   = 4'd8;
    end else begin
      code_la = {Prefix4, m22[7:0], neg};
      ncode   = 4'd12;
    end

    total = {2'b0, bit_count} + {1'b0, ncode};
    nfull = total[4:3];
    rem   = total[2:0];
    win   = {acc_la, {(WinW-AccW){1'b0}}} | ({code_la, {(WinW-CodeW){1'b0}}} >> bit_count);
    bytes[0] = win[23:16];
    bytes[1] = win[15:8];
    bytes[2] = win[7:0];

    case (nfull)
      2'd0:    tail = bytes[0];
      2'd1:    tail = bytes[1];
      2'd2:    tail = bytes[2];
      default: tail = '0;
    endcase

    flush = in_last && (rem != 3'd0);
    nres  = nfull + {1'b0, flush};

    for (int i = 0; i < NumSlots; i++) begin
      res[i].data  = bytes[i];
      res[i].vbits = FullByteBits;
      res[i].last  = in_last && (rem == 3'd0) && ({1'b0, nfull} == 3'(i + 1));
      if (flush && (nfull == 2'(i))) begin
        res[i].vbits = {1'b0, rem};
        res[i].last  = 1'b1;
      end
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_pixel <= s_axis_tdata;
      in_last  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pixel    <= '0;
      first_pending <= 1'b1;
      acc_la        <= '0;
      bit_count     <= '0;
    end else if (move) begin
      if (in_last) begin
        prev_pixel    <= '0;
        first_pending <= 1'b1;
        acc_la        <= '0;
        bit_count     <= '0;
      end else begin
        prev_pixel    <= in_pixel;
        first_pending <= 1'b0;
        acc_la        <= tail[7:1];
        bit_count     <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= move ? nres : 2'd0;
    end else if (drain) begin
      cnt <= cnt - 2'd1;
    end
    if (move) begin
      for (int i = 0; i < NumSlots; i++) slots[i] <= res[i];
    end else if (drain) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = {4'b0, slots[0].vbits, slots[0].data};
  assign m_axis_tlast  = slots[0].last;

  // ---- checks ----
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc_la & (7'h7f >> bit_count)) == 7'd0)
    else $error("pending bits below count not zero");

  a_first_empty: assert property (@(posedge clk) disable iff (rst)
    first_pending |-> (bit_count == 3'd0 && acc_la == 7'd0))
    else $error("raw pixel pending with leftover code bits");

  a_partial_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[11:8] != FullByteBits) |-> m_axis_tlast)
    else $error("partial byte not marked last");

  a_vbits_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:8] != 4'd0 && m_axis_tdata[11:8] <= FullByteBits))
    else $error("bad valid_bits");

endmodule
